@@ src/kbds_pkg.sv @@
package kbds_pkg;

   localparam int KEY_CODE_W = 5;
   localparam int TIME_W     = 32;
   localparam int HOLD_W     = 16;
   localparam int DIGIT_W    = 4;

   localparam logic [HOLD_W-1:0] KEY_HOLD_RESET    = 16'd50;
   localparam logic [HOLD_W-1:0] BUTTON_HOLD_RESET = 16'd30;

   localparam logic [KEY_CODE_W-1:0] KEY_NONE  = 5'd0;
   localparam logic [DIGIT_W-1:0]    NOT_DIGIT = 4'hF;

   typedef enum logic [1:0] {
      KIND_POLL     = 2'd0,
      KIND_CONSUME  = 2'd1,
      KIND_CLEAR_IR = 2'd2,
      KIND_UNUSED   = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_KEY_HOLD    = 1'b0,
      CSR_BUTTON_HOLD = 1'b1
   } csr_index_type;

   // digit per key index row*4+col
   localparam logic [DIGIT_W-1:0] DIGIT_OF [16] = '{
      4'd1, 4'd4, 4'd7, NOT_DIGIT,
      4'd2, 4'd5, 4'd8, 4'd0,
      4'd3, 4'd6, 4'd9, NOT_DIGIT,
      NOT_DIGIT, NOT_DIGIT, NOT_DIGIT, NOT_DIGIT
   };

   // first closed key, column outer and row inner; code is 1 + row*4 + col
   function automatic logic [KEY_CODE_W-1:0] scan_matrix(input logic [15:0] matrix);
      logic [KEY_CODE_W-1:0] code;
      code = KEY_NONE;
      for (int i = 15; i >= 0; i--) begin
         if (!matrix[i]) begin
            code = KEY_CODE_W'(1 + (i % 4) * 4 + (i / 4));
         end
      end
      return code;
   endfunction

endpackage

@@ src/keypad_button_debounce_snapshot_top.sv @@
// keypad and button debounce snapshot
//
// req channel carries one transaction per poll or command: tuser holds the
// kind (poll, consume digit, clear ir), tdata holds the timestamp and raw
// keypad, button and ir samples. every req transaction yields exactly one rsp
// transaction holding the current snapshot: a poll refreshes it, the other
// kinds repeat the last one after updating key or ir state.
// csr channel writes the key and button hold times; it is always ready.
//
// rsp_tvalid is registered and rises in the cycle after req acceptance.
// throughput is one transaction per cycle while rsp_tready is high: the rsp
// register is reloaded in the same cycle its contents are taken, set by the
// single scan, subtract and compare pass on the debounce registers.
// when the receiver stalls, the rsp register holds and req_tready drops
// until the pending result is taken.
// reset (synchronous) clears all debounce state and the snapshot, and loads
// hold times of 50 ms (key) and 30 ms (buttons).
module keypad_button_debounce_snapshot_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms[31:0], key_matrix[47:32], button_port[49:48], ir_valid_frame[50], zero[55:51]
   input  logic [55:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // snap_time_ms[31:0], both_pressed[32], ir_confirmed[33], digit_valid[34],
   // digit_value[38:35], zero[39]
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import kbds_pkg::*;

   logic [HOLD_W-1:0]     key_hold_ff, button_hold_ff;
   logic [KEY_CODE_W-1:0] raw_key_prev_ff, raw_key_prev_in;
   logic [KEY_CODE_W-1:0] stable_key_ff, stable_key_in;
   logic [TIME_W-1:0]     key_change_time_ff, key_change_time_in;
   logic                  raw_buttons_prev_ff, raw_buttons_prev_in;
   logic                  stable_buttons_ff, stable_buttons_in;
   logic [TIME_W-1:0]     button_change_time_ff, button_change_time_in;
   logic                  ir_pending_ff, ir_pending_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]     snap_time_ff, snap_time_in;
   logic                  snap_both_ff, snap_both_in;
   logic                  snap_ir_ff, snap_ir_in;
   logic                  snap_dvalid_ff, snap_dvalid_in;
   logic [DIGIT_W-1:0]    snap_dvalue_ff, snap_dvalue_in;

   logic                  req_accept;
   kind_type              kind;
   logic [TIME_W-1:0]     now_ms;
   logic [15:0]           key_matrix;
   logic [1:0]            button_port;
   logic                  ir_valid_frame;
   logic                  raw_buttons;
   logic [KEY_CODE_W-1:0] raw_key;
   logic [TIME_W-1:0]     button_age, key_age;
   logic [DIGIT_W-1:0]    digit;

   assign kind           = kind_type'(req_tuser);
   assign now_ms         = req_tdata[31:0];
   assign key_matrix     = req_tdata[47:32];
   assign button_port    = req_tdata[49:48];
   assign ir_valid_frame = req_tdata[50];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign raw_buttons = (button_port == 2'b00);
   assign raw_key     = scan_matrix(key_matrix);

   always_comb begin
      raw_key_prev_in       = raw_key_prev_ff;
      stable_key_in         = stable_key_ff;
      key_change_time_in    = key_change_time_ff;
      raw_buttons_prev_in   = raw_buttons_prev_ff;
      stable_buttons_in     = stable_buttons_ff;
      button_change_time_in = button_change_time_ff;
      ir_pending_in         = ir_pending_ff;
      snap_time_in          = snap_time_ff;
      snap_both_in          = snap_both_ff;
      snap_ir_in            = snap_ir_ff;
      snap_dvalid_in        = snap_dvalid_ff;
      snap_dvalue_in        = snap_dvalue_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_tready;
      button_age            = '0;
      key_age               = '0;
      digit                 = NOT_DIGIT;

      if (req_accept) begin
         rsp_valid_in = 1'b1;
         case (kind)
            KIND_POLL: begin
               if (raw_buttons != raw_buttons_prev_ff) begin
                  button_change_time_in = now_ms;
                  raw_buttons_prev_in   = raw_buttons;
               end
               button_age = now_ms - button_change_time_in;
               if (button_age >= TIME_W'(button_hold_ff)) begin
                  stable_buttons_in = raw_buttons;
               end

               if (raw_key != raw_key_prev_ff) begin
                  key_change_time_in = now_ms;
                  raw_key_prev_in    = raw_key;
               end
               key_age = now_ms - key_change_time_in;
               if (key_age >= TIME_W'(key_hold_ff)) begin
                  stable_key_in = raw_key;
               end

               if (stable_key_in != KEY_NONE) begin
                  digit = DIGIT_OF[4'(stable_key_in - 5'd1)];
               end

               snap_time_in   = now_ms;
               snap_both_in   = stable_buttons_in;
               // pending flag is reported once and then dropped
               snap_ir_in     = ir_pending_ff || ir_valid_frame;
               snap_dvalid_in = (digit != NOT_DIGIT);
               snap_dvalue_in = (digit != NOT_DIGIT) ? digit : '0;
               ir_pending_in  = 1'b0;
            end
            KIND_CONSUME: begin
               stable_key_in   = KEY_NONE;
               raw_key_prev_in = KEY_NONE;
            end
            KIND_CLEAR_IR: begin
               ir_pending_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hold_ff           <= KEY_HOLD_RESET;
         button_hold_ff        <= BUTTON_HOLD_RESET;
         raw_key_prev_ff       <= KEY_NONE;
         stable_key_ff         <= KEY_NONE;
         key_change_time_ff    <= '0;
         raw_buttons_prev_ff   <= 1'b0;
         stable_buttons_ff     <= 1'b0;
         button_change_time_ff <= '0;
         ir_pending_ff         <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         snap_time_ff          <= '0;
         snap_both_ff          <= 1'b0;
         snap_ir_ff            <= 1'b0;
         snap_dvalid_ff        <= 1'b0;
         snap_dvalue_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_KEY_HOLD:    key_hold_ff    <= csr_data;
               CSR_BUTTON_HOLD: button_hold_ff <= csr_data;
               default: begin
               end
            endcase
         end
         raw_key_prev_ff       <= raw_key_prev_in;
         stable_key_ff         <= stable_key_in;
         key_change_time_ff    <= key_change_time_in;
         raw_buttons_prev_ff   <= raw_buttons_prev_in;
         stable_buttons_ff     <= stable_buttons_in;
         button_change_time_ff <= button_change_time_in;
         ir_pending_ff         <= ir_pending_in;
         rsp_valid_ff          <= rsp_valid_in;
         snap_time_ff          <= snap_time_in;
         snap_both_ff          <= snap_both_in;
         snap_ir_ff            <= snap_ir_in;
         snap_dvalid_ff        <= snap_dvalid_in;
         snap_dvalue_ff        <= snap_dvalue_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, snap_dvalue_ff, snap_dvalid_ff, snap_ir_ff, snap_both_ff,
                        snap_time_ff};

   // a poll always leaves no ir confirmation pending
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (kind == KIND_POLL) |=> !ir_pending_ff)
      else $error("ir pending survived a poll");

   // snapshot only changes on an accepted poll
   assert property (@(posedge clock) disable iff (reset)
      !(req_accept && (kind == KIND_POLL)) |=> $stable(rsp_tdata))
      else $error("snapshot changed without a poll");

   // digit value is zero unless a digit is shown, and never above nine
   assert property (@(posedge clock) disable iff (reset)
      (snap_dvalid_ff || (snap_dvalue_ff == '0)) && (snap_dvalue_ff <= 4'd9))
      else $error("bad digit field");

   // a consume leaves no stable key behind
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (kind == KIND_CONSUME) |=> stable_key_ff == KEY_NONE)
      else $error("stable key kept after consume");

   // every accepted transaction shows up as a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("response missing after accepted transaction");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import kbds_pkg::*;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit_value;
      logic               digit_valid;
      logic               ir_confirmed;
      logic               both_pressed;
      logic [TIME_W-1:0]  snap_time_ms;
   } snapshot_type;

   class snapshot_scoreboard;
      logic [HOLD_W-1:0]     key_hold;
      logic [HOLD_W-1:0]     button_hold;
      logic [KEY_CODE_W-1:0] raw_key_prev;
      logic [KEY_CODE_W-1:0] stable_key;
      logic [TIME_W-1:0]     key_change_ms;
      logic                  raw_buttons_prev;
      logic                  stable_buttons;
      logic [TIME_W-1:0]     button_change_ms;
      logic                  ir_pending;
      snapshot_type          snapshot;
      snapshot_type          snapshot_q[$];
      int                    mismatches;

      function new();
         key_hold         = KEY_HOLD_RESET;
         button_hold      = BUTTON_HOLD_RESET;
         raw_key_prev     = KEY_NONE;
         stable_key       = KEY_NONE;
         key_change_ms    = '0;
         raw_buttons_prev = 1'b0;
         stable_buttons   = 1'b0;
         button_change_ms = '0;
         ir_pending       = 1'b0;
         snapshot         = '0;
         mismatches       = 0;
      endfunction

      function void set_hold(csr_index_type idx, logic [HOLD_W-1:0] value);
         if (idx == CSR_KEY_HOLD) begin
            key_hold = value;
         end else begin
            button_hold = value;
         end
      endfunction

      // column outer, row inner; code is 1 + row*4 + col
      function logic [KEY_CODE_W-1:0] first_closed_key(logic [15:0] matrix);
         logic [KEY_CODE_W-1:0] code;
         code = KEY_NONE;
         for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
               if (code == KEY_NONE && !matrix[col*4+row]) begin
                  code = KEY_CODE_W'(1 + row*4 + col);
               end
            end
         end
         return code;
      endfunction

      // returns {is_digit, value}; keypad is laid out rotated
      function logic [DIGIT_W:0] digit_of_key(logic [KEY_CODE_W-1:0] code);
         case (code)
            5'd1:    return {1'b1, 4'd1};
            5'd2:    return {1'b1, 4'd4};
            5'd3:    return {1'b1, 4'd7};
            5'd5:    return {1'b1, 4'd2};
            5'd6:    return {1'b1, 4'd5};
            5'd7:    return {1'b1, 4'd8};
            5'd8:    return {1'b1, 4'd0};
            5'd9:    return {1'b1, 4'd3};
            5'd10:   return {1'b1, 4'd6};
            5'd11:   return {1'b1, 4'd9};
            default: return {1'b0, 4'd0};
         endcase
      endfunction

      function void note_request(kind_type kind, logic [TIME_W-1:0] now,
                                 logic [15:0] matrix, logic [1:0] buttons, logic ir);
         logic                  raw_buttons;
         logic [KEY_CODE_W-1:0] raw_key;
         logic [DIGIT_W:0]      digit;
         case (kind)
            KIND_CONSUME: begin
               stable_key   = KEY_NONE;
               raw_key_prev = KEY_NONE;
            end
            KIND_CLEAR_IR: begin
               ir_pending = 1'b0;
            end
            KIND_POLL: begin
               if (ir) begin
                  ir_pending = 1'b1;
               end
               raw_buttons = (buttons == 2'b00);
               if (raw_buttons != raw_buttons_prev) begin
                  button_change_ms = now;
                  raw_buttons_prev = raw_buttons;
               end
               // elapsed time wraps modulo 2^32
               if (TIME_W'(now - button_change_ms) >= {16'd0, button_hold}) begin
                  stable_buttons = raw_buttons;
               end
               raw_key = first_closed_key(matrix);
               if (raw_key != raw_key_prev) begin
                  key_change_ms = now;
                  raw_key_prev  = raw_key;
               end
               if (TIME_W'(now - key_change_ms) >= {16'd0, key_hold}) begin
                  stable_key = raw_key;
               end
               digit                 = digit_of_key(stable_key);
               snapshot.snap_time_ms = now;
               snapshot.both_pressed = stable_buttons;
               snapshot.ir_confirmed = ir_pending;
               snapshot.digit_valid  = digit[DIGIT_W];
               snapshot.digit_value  = digit[DIGIT_W-1:0];
               ir_pending            = 1'b0;
            end
            default: begin
            end
         endcase
         snapshot_q.push_back(snapshot);
      endfunction

      function void report_field(string field, logic [TIME_W-1:0] exp_val,
                                 logic [TIME_W-1:0] act_val);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_val, act_val);
         end
      endfunction

      function void check_snapshot(logic [39:0] data);
         snapshot_type act;
         snapshot_type exp;
         act = snapshot_type'(data[38:0]);
         if (snapshot_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected rsp transaction %h", $time, data);
            end
            return;
         end
         exp = snapshot_q.pop_front();
         if (act.snap_time_ms != exp.snap_time_ms) begin
            report_field("snap_time_ms", exp.snap_time_ms, act.snap_time_ms);
         end
         if (act.both_pressed != exp.both_pressed) begin
            report_field("both_pressed", TIME_W'(exp.both_pressed), TIME_W'(act.both_pressed));
         end
         if (act.ir_confirmed != exp.ir_confirmed) begin
            report_field("ir_confirmed", TIME_W'(exp.ir_confirmed), TIME_W'(act.ir_confirmed));
         end
         if (act.digit_valid != exp.digit_valid) begin
            report_field("digit_valid", TIME_W'(exp.digit_valid), TIME_W'(act.digit_valid));
         end
         if (act.digit_value != exp.digit_value) begin
            report_field("digit_value", TIME_W'(exp.digit_value), TIME_W'(act.digit_value));
         end
      endfunction

      function int pending();
         return snapshot_q.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = KIND_POLL;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = CSR_KEY_HOLD;
   logic [15:0] csr_data   = '0;

   snapshot_scoreboard sb = new();

   int          sender_idle_pct = 0;
   int          recv_stall_pct  = 0;
   logic [31:0] poll_ms         = '0;

   keypad_button_debounce_snapshot_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(kind_type'(req_tuser), req_tdata[31:0], req_tdata[47:32],
                            req_tdata[49:48], req_tdata[50]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_snapshot(rsp_tdata);
         end
      end
   end

   task automatic send_req(kind_type kind, logic [31:0] now, logic [15:0] matrix,
                           logic [1:0] buttons, logic ir);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, ir, buttons, matrix, now};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_hold(idx, value);
   endtask

   task automatic write_holds(logic [15:0] key_hold, logic [15:0] button_hold);
      write_reg(CSR_KEY_HOLD, key_hold);
      write_reg(CSR_BUTTON_HOLD, button_hold);
      csr_valid <= 1'b0;
   endtask

   // stop sending and let every outstanding snapshot come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] time_step();
      int r;
      int span;
      r    = $urandom_range(0, 99);
      span = ((sb.key_hold > sb.button_hold) ? sb.key_hold : sb.button_hold) / 3 + 1;
      if (r < 10) begin
         return 32'd0;
      end else if (r < 65) begin
         return $urandom_range(1, span);
      end else if (r < 90) begin
         return $urandom_range(1, 8);
      end
      return $urandom;
   endfunction

   task automatic run_random_polls(int count);
      int          sent;
      int          r;
      int          len;
      bit          paused;
      logic [15:0] matrix;
      logic [15:0] sample;
      logic [1:0]  buttons;
      kind_type    kind;
      sent   = 0;
      paused = 0;
      while (sent < count) begin
         if (!paused && sent >= count / 2) begin
            wait_drained();
            paused = 1;
         end
         r = $urandom_range(0, 99);
         if (r < 70) begin
            // held key and buttons with bounce, then often a consume or ir clear
            r = $urandom_range(0, 99);
            if (r < 55) begin
               matrix = ~(16'h1 << $urandom_range(0, 15));
            end else if (r < 70) begin
               matrix = 16'hFFFF;
            end else if (r < 85) begin
               matrix = 16'($urandom) | 16'($urandom);
            end else begin
               matrix = 16'($urandom);
            end
            buttons = ($urandom_range(0, 1) == 0) ? 2'b00 : 2'($urandom_range(0, 3));
            len = $urandom_range(2, 12);
            for (int i = 0; i < len; i++) begin
               sample = matrix;
               if ($urandom_range(0, 9) == 0) begin
                  sample = matrix ^ (16'h1 << $urandom_range(0, 15));
               end
               poll_ms = poll_ms + time_step();
               send_req(KIND_POLL, poll_ms, sample, buttons, ($urandom_range(0, 9) == 0));
               sent++;
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
               send_req(KIND_CONSUME, $urandom, 16'($urandom), 2'($urandom), 1'($urandom));
               sent++;
            end else if (r < 55) begin
               send_req(KIND_CLEAR_IR, $urandom, 16'($urandom), 2'($urandom), 1'($urandom));
               sent++;
            end
         end else if (r < 85) begin
            poll_ms = $urandom;
            send_req(KIND_POLL, poll_ms, 16'($urandom), 2'($urandom), 1'($urandom));
            sent++;
         end else begin
            kind = kind_type'($urandom_range(1, 3));
            send_req(kind, $urandom, 16'($urandom), 2'($urandom), 1'($urandom));
            if (kind != KIND_UNUSED) begin
               sent++;
            end
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [15:0] key_hold;
      logic [15:0] button_hold;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset hold times: key 50 ms, buttons 30 ms
      send_req(KIND_POLL, 32'd0, 16'hFFFF, 2'b11, 1'b0);
      send_req(KIND_POLL, 32'd10, 16'hFFFE, 2'b00, 1'b1);
      send_req(KIND_POLL, 32'd60, 16'hFFFE, 2'b00, 1'b0);
      send_req(KIND_CONSUME, $urandom, 16'($urandom), 2'($urandom), 1'b1);
      send_req(KIND_POLL, 32'd61, 16'hFFFE, 2'b00, 1'b1);
      send_req(KIND_POLL, 32'd62, 16'hFFFE, 2'b01, 1'b1);
      send_req(KIND_CLEAR_IR, $urandom, 16'($urandom), 2'($urandom), 1'b1);
      send_req(KIND_POLL, 32'd63, 16'hFFFE, 2'b10, 1'b0);
      send_req(KIND_UNUSED, 32'hFFFF_FFFF, 16'h0000, 2'b00, 1'b1);
      // every key closed: column 0 row 0 wins
      send_req(KIND_POLL, 32'd200, 16'h0000, 2'b00, 1'b0);
      send_req(KIND_POLL, 32'd300, 16'h7FFF, 2'b00, 1'b0);
      send_req(KIND_POLL, 32'd400, 16'h7FFF, 2'b00, 1'b0);
      wait_drained();

      // zero hold: each change is taken on the same poll, time wraps through zero
      write_holds(16'd0, 16'd0);
      for (int i = 0; i < 16; i++) begin
         send_req(KIND_POLL, 32'hFFFF_FFF8 + i, ~(16'h1 << i), 2'(i), 1'(i));
      end

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               key_hold    = 16'hFFFF;
               button_hold = 16'd0;
            end
            1: begin
               key_hold    = 16'($urandom_range(0, 200));
               button_hold = 16'($urandom_range(0, 200));
            end
            2: begin
               key_hold    = 16'd1;
               button_hold = 16'hFFFF;
            end
            default: begin
               key_hold    = 16'($urandom);
               button_hold = 16'd50;
            end
         endcase
         wait_drained();
         write_holds(key_hold, button_hold);
         sender_idle_pct = (p == 1) ? 65 : (p == 3) ? 33 : 0;
         recv_stall_pct  = (p == 2) ? 65 : (p == 3) ? 33 : 0;
         if (p == 2) begin
            poll_ms = 32'hFFFF_0000;
         end
         run_random_polls(300);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
